// File: src/dls_pkg.sv
// Shared constants and codes for the dense layer SGD engine.
// No dependencies; every other file imports this package.
package dls_pkg;

   localparam int IN_MAX_DEF     = 16;
   localparam int OUT_MAX_DEF    = 16;
   localparam int BATCH_MAX_DEF  = 32;
   localparam int VALUE_BITS_DEF = 16;

   localparam int ACC_BITS  = 40;
   localparam int LR_BITS   = 16;
   localparam int INT_BITS  = 4;
   localparam int ROW_W     = 5;
   localparam int FIDX_W    = 4;
   localparam int USED_W    = 5;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [LR_BITS-1:0] LEARN_RATE_RESET = 16'd655;
   localparam logic [USED_W-1:0]  USED_RESET       = 5'd16;

   typedef enum logic [1:0] {
      OP_WEIGHT   = 2'd0,
      OP_FORWARD  = 2'd1,
      OP_BACKWARD = 2'd2,
      OP_NONE     = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEARN_RATE = 2'd0,
      CSR_IN_USED    = 2'd1,
      CSR_OUT_USED   = 2'd2
   } csr_index_type;

endpackage

// File: src/dls_req_if.sv
// Request channel of the dense layer SGD engine: valid, ready and one element.
// Depends on dls_pkg.
interface dls_req_if #(
   parameter int VALUE_BITS = dls_pkg::VALUE_BITS_DEF
);
   import dls_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [1:0]                   opcode;
   logic [ROW_W-1:0]             batch_row;
   logic [FIDX_W-1:0]            in_index;
   logic [FIDX_W-1:0]            out_index;
   logic signed [VALUE_BITS-1:0] value;
   logic                         row_end;
   logic                         batch_end;

   modport source (
      output valid, opcode, batch_row, in_index, out_index, value, row_end, batch_end,
      input  ready
   );
   modport sink (
      input  valid, opcode, batch_row, in_index, out_index, value, row_end, batch_end,
      output ready
   );
endinterface

// File: src/dls_rsp_if.sv
// Result channel of the dense layer SGD engine: valid, ready and one result.
// Depends on dls_pkg.
interface dls_rsp_if #(
   parameter int VALUE_BITS = dls_pkg::VALUE_BITS_DEF
);
   import dls_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [ROW_W-1:0]             result_row;
   logic [FIDX_W-1:0]            result_index;
   logic signed [VALUE_BITS-1:0] result_value;
   logic                         last;

   modport source (
      output valid, kind, result_row, result_index, result_value, last,
      input  ready
   );
   modport sink (
      input  valid, kind, result_row, result_index, result_value, last,
      output ready
   );
endinterface

// File: src/dense_layer_sgd_engine_core.sv
// Dense layer engine with plain SGD: weight store, batch input store, accumulators.
// Depends on dls_pkg, dls_req_if and dls_rsp_if.
//
// Forward elements run read, multiply, accumulate per output in use, backward ones
// read, multiply, two accumulates per input in use, then post and update check;
// weight writes are done on acceptance. A row end sends the results, waiting on
// result-side stalls. A batch end runs read, two multiply halves, sum and write per
// weight in use. This comes from the single shared multiplier and the single-port
// weight and gradient memories, stepped one feature at a time. Requests are not
// taken while an element is being worked on. No clearing pass is needed after reset.
module dense_layer_sgd_engine_core #(
   parameter int IN_MAX     = dls_pkg::IN_MAX_DEF,
   parameter int OUT_MAX    = dls_pkg::OUT_MAX_DEF,
   parameter int BATCH_MAX  = dls_pkg::BATCH_MAX_DEF,
   parameter int VALUE_BITS = dls_pkg::VALUE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   dls_req_if.sink                          req_chan,
   dls_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [dls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dls_pkg::CSR_W-1:0]        csr_wdata
);
   import dls_pkg::*;

   localparam int VB      = VALUE_BITS;
   localparam int FRAC    = VB - INT_BITS;
   localparam int ACC_LEN = (IN_MAX > OUT_MAX) ? IN_MAX : OUT_MAX;
   localparam int CW      = $clog2(ACC_LEN + 1);
   localparam int IW      = (ACC_LEN > 1) ? $clog2(ACC_LEN) : 1;
   localparam int GN      = IN_MAX * OUT_MAX;
   localparam int WA_W    = (GN > 1) ? $clog2(GN) : 1;
   localparam int XN      = BATCH_MAX * IN_MAX;
   localparam int XA_W    = (XN > 1) ? $clog2(XN) : 1;
   localparam int GL_W    = ACC_BITS / 2;
   localparam int MA      = (VB > GL_W + 1) ? VB : GL_W + 1;
   localparam int MB      = (VB > LR_BITS + 1) ? VB : LR_BITS + 1;
   localparam int PW      = MA + MB;
   localparam int SW      = ((PW > 52) ? PW : 52) + 1;
   localparam int USW     = ACC_BITS + LR_BITS + 2;
   localparam int USH     = FRAC + LR_BITS;

   localparam logic signed [SW-1:0] PCAP = SW'(1) <<< 50;
   localparam logic signed [SW-1:0] AMAX = (SW'(1) <<< (ACC_BITS - 1)) - SW'(1);
   localparam logic signed [SW-1:0] AMIN = -(SW'(1) <<< (ACC_BITS - 1));
   localparam logic signed [ACC_BITS:0] R_HALF = (ACC_BITS + 1)'(1) <<< (FRAC - 1);
   localparam logic signed [ACC_BITS:0] R_MAX =
      ((ACC_BITS + 1)'(1) <<< (VB - 1)) - (ACC_BITS + 1)'(1);
   localparam logic signed [ACC_BITS:0] R_MIN = -((ACC_BITS + 1)'(1) <<< (VB - 1));
   localparam logic signed [USW-1:0] U_HALF = USW'(1) <<< (USH - 1);
   localparam logic signed [USW-1:0] U_MAX = (USW'(1) <<< (VB - 1)) - USW'(1);
   localparam logic signed [USW-1:0] U_MIN = -(USW'(1) <<< (VB - 1));
   localparam logic signed [VB:0] V_MAX = ((VB + 1)'(1) <<< (VB - 1)) - (VB + 1)'(1);
   localparam logic signed [VB:0] V_MIN = -((VB + 1)'(1) <<< (VB - 1));

   typedef enum logic [3:0] {
      ST_IDLE, ST_F_RD, ST_F_MUL, ST_F_ACC, ST_B_RD, ST_B_MUL, ST_B_ACC1, ST_B_ACC2,
      ST_POST, ST_EMIT, ST_UCHK, ST_U_RD, ST_U_MLO, ST_U_MHI, ST_U_SUM, ST_U_WR
   } state_type;

   function automatic logic signed [ACC_BITS-1:0] acc_add(
      input logic signed [ACC_BITS-1:0] a,
      input logic signed [PW-1:0]       p
   );
      logic signed [SW-1:0] pe;
      logic signed [SW-1:0] s;
      pe = SW'(p);
      if (pe > PCAP) pe = PCAP;
      else if (pe < -PCAP) pe = -PCAP;
      s = SW'(a) + pe;
      if (s > AMAX) s = AMAX;
      else if (s < AMIN) s = AMIN;
      return ACC_BITS'(s);
   endfunction

   function automatic logic signed [VB-1:0] round_acc(input logic signed [ACC_BITS-1:0] a);
      logic signed [ACC_BITS:0] t;
      t = ((ACC_BITS + 1)'(a) + R_HALF) >>> FRAC;
      if (t > R_MAX) t = R_MAX;
      else if (t < R_MIN) t = R_MIN;
      return VB'(t);
   endfunction

   state_type                  state_ff;
   logic [CW-1:0]              cnt_ff, ui_ff, uj_ff;
   opcode_type                 op_ff;
   logic [ROW_W-1:0]           row_ff;
   logic [FIDX_W-1:0]          ii_ff, oi_ff;
   logic signed [VB-1:0]       v_ff;
   logic                       rend_ff, bend_ff;
   logic [LR_BITS-1:0]         learn_rate_ff;
   logic [USED_W-1:0]          in_used_ff, out_used_ff;
   logic signed [ACC_BITS-1:0] row_acc_ff [ACC_LEN];
   logic [GN-1:0]              grad_vld_ff;
   logic signed [PW-1:0]       prod_ff;
   logic signed [USW-1:0]      usum_ff;
   logic signed [VB-1:0]       step_ff;
   logic signed [VB-1:0]       w_rd_ff, x_rd_ff;
   logic signed [ACC_BITS-1:0] g_rd_ff;
   logic                       rsp_valid_ff, rsp_kind_ff, rsp_last_ff;
   logic [ROW_W-1:0]           rsp_row_ff;
   logic [FIDX_W-1:0]          rsp_index_ff;
   logic signed [VB-1:0]       rsp_value_ff;

   logic signed [VB-1:0]       w_mem [GN];
   logic signed [VB-1:0]       x_mem [XN];
   logic signed [ACC_BITS-1:0] g_mem [GN];

   logic [CW-1:0]        n_in, n_out, n_emit;
   logic                 req_acc, fwd_ok, bwd_ok;
   logic [WA_W-1:0]      w_addr, g_addr;
   logic [XA_W-1:0]      x_addr;
   logic                 w_we, w_re, x_we, x_re, g_we, g_re;
   logic signed [VB-1:0] w_wdata;
   logic signed [MA-1:0] mul_a;
   logic signed [MB-1:0] mul_b;
   logic signed [PW-1:0] mul_p;
   logic signed [USW-1:0] u_rnd;
   logic signed [VB:0]   w_diff;
   logic                 emit_go, emit_last, upd_last;

   assign n_in  = (int'(in_used_ff) > IN_MAX) ? CW'(IN_MAX) : CW'(in_used_ff);
   assign n_out = (int'(out_used_ff) > OUT_MAX) ? CW'(OUT_MAX) : CW'(out_used_ff);
   assign n_emit = (op_ff == OP_FORWARD) ? n_out : n_in;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc = req_chan.valid && req_chan.ready;
   assign fwd_ok = (int'(req_chan.in_index) < int'(n_in)) &&
                   (int'(req_chan.batch_row) < BATCH_MAX);
   assign bwd_ok = (int'(req_chan.out_index) < int'(n_out)) &&
                   (int'(req_chan.batch_row) < BATCH_MAX);

   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);
   assign emit_last = (cnt_ff + CW'(1)) == n_emit;
   assign upd_last  = ((uj_ff + CW'(1)) == n_out) && ((ui_ff + CW'(1)) == n_in);

   always_comb begin
      w_addr  = '0;
      w_we    = 1'b0;
      w_wdata = v_ff;
      unique case (state_ff)
         ST_IDLE: begin
            w_addr  = WA_W'(int'(req_chan.in_index) * OUT_MAX + int'(req_chan.out_index));
            w_we    = req_acc && (opcode_type'(req_chan.opcode) == OP_WEIGHT) &&
                      (int'(req_chan.in_index) < int'(n_in)) &&
                      (int'(req_chan.out_index) < int'(n_out));
            w_wdata = req_chan.value;
         end
         ST_F_RD: w_addr = WA_W'(int'(ii_ff) * OUT_MAX + int'(cnt_ff));
         ST_B_RD: w_addr = WA_W'(int'(cnt_ff) * OUT_MAX + int'(oi_ff));
         ST_U_RD: w_addr = WA_W'(int'(ui_ff) * OUT_MAX + int'(uj_ff));
         ST_U_WR: begin
            w_addr  = WA_W'(int'(ui_ff) * OUT_MAX + int'(uj_ff));
            w_we    = 1'b1;
            w_wdata = (w_diff > V_MAX) ? VB'(V_MAX) :
                      (w_diff < V_MIN) ? VB'(V_MIN) : VB'(w_diff);
         end
         default: w_addr = '0;
      endcase
   end

   assign w_re = (state_ff == ST_F_RD) || (state_ff == ST_B_RD) || (state_ff == ST_U_RD);
   assign w_diff = (VB + 1)'(w_rd_ff) - (VB + 1)'(step_ff);

   always_comb begin
      if (state_ff == ST_IDLE) begin
         x_addr = XA_W'(int'(req_chan.batch_row) * IN_MAX + int'(req_chan.in_index));
      end else begin
         x_addr = XA_W'(int'(row_ff) * IN_MAX + int'(cnt_ff));
      end
   end
   assign x_we = req_acc && (opcode_type'(req_chan.opcode) == OP_FORWARD) && fwd_ok;
   assign x_re = (state_ff == ST_B_RD);

   always_comb begin
      if (state_ff == ST_U_RD) begin
         g_addr = WA_W'(int'(ui_ff) * OUT_MAX + int'(uj_ff));
      end else begin
         g_addr = WA_W'(int'(cnt_ff) * OUT_MAX + int'(oi_ff));
      end
   end
   assign g_re = (state_ff == ST_B_RD) || (state_ff == ST_U_RD);
   assign g_we = (state_ff == ST_B_ACC2);

   always_comb begin
      mul_a = MA'(v_ff);
      mul_b = MB'(w_rd_ff);
      unique case (state_ff)
         ST_B_ACC1: begin
            mul_a = MA'(x_rd_ff);
            mul_b = MB'(v_ff);
         end
         ST_U_MLO: begin
            mul_a = MA'(signed'({1'b0, g_rd_ff[GL_W-1:0]}));
            mul_b = MB'(signed'({1'b0, learn_rate_ff}));
         end
         ST_U_MHI: begin
            mul_a = MA'(signed'(g_rd_ff[ACC_BITS-1:GL_W]));
            mul_b = MB'(signed'({1'b0, learn_rate_ff}));
         end
         default: mul_a = MA'(v_ff);
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign u_rnd = (usum_ff + (USW'(prod_ff) <<< GL_W) + U_HALF) >>> USH;

   always_ff @(posedge clock) begin
      if (w_we) w_mem[w_addr] <= w_wdata;
      if (w_re) w_rd_ff <= w_mem[w_addr];
   end

   always_ff @(posedge clock) begin
      if (x_we) x_mem[x_addr] <= req_chan.value;
      if (x_re) x_rd_ff <= x_mem[x_addr];
   end

   always_ff @(posedge clock) begin
      if (g_we) g_mem[g_addr] <= acc_add(g_rd_ff, prod_ff);
      if (g_re) g_rd_ff <= grad_vld_ff[g_addr] ? g_mem[g_addr] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff <= LEARN_RATE_RESET;
         in_used_ff    <= USED_RESET;
         out_used_ff   <= USED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LEARN_RATE: learn_rate_ff <= csr_wdata[LR_BITS-1:0];
            CSR_IN_USED:    in_used_ff    <= csr_wdata[USED_W-1:0];
            CSR_OUT_USED:   out_used_ff   <= csr_wdata[USED_W-1:0];
            default:        learn_rate_ff <= learn_rate_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ui_ff        <= '0;
         uj_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         grad_vld_ff  <= '0;
         for (int k = 0; k < ACC_LEN; k++) row_acc_ff[k] <= '0;
      end else begin
         if (rsp_chan.ready && !emit_go) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  op_ff   <= opcode_type'(req_chan.opcode);
                  row_ff  <= req_chan.batch_row;
                  ii_ff   <= req_chan.in_index;
                  oi_ff   <= req_chan.out_index;
                  v_ff    <= req_chan.value;
                  rend_ff <= req_chan.row_end;
                  bend_ff <= req_chan.batch_end;
                  cnt_ff  <= '0;
                  unique case (opcode_type'(req_chan.opcode))
                     OP_FORWARD:
                        state_ff <= (fwd_ok && n_out != '0) ? ST_F_RD : ST_POST;
                     OP_BACKWARD:
                        state_ff <= (bwd_ok && n_in != '0) ? ST_B_RD : ST_POST;
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_F_RD:  state_ff <= ST_F_MUL;
            ST_F_MUL: begin
               prod_ff  <= mul_p;
               state_ff <= ST_F_ACC;
            end
            ST_F_ACC: begin
               row_acc_ff[cnt_ff[IW-1:0]] <= acc_add(row_acc_ff[cnt_ff[IW-1:0]], prod_ff);
               cnt_ff <= cnt_ff + CW'(1);
               state_ff <= ((cnt_ff + CW'(1)) == n_out) ? ST_POST : ST_F_RD;
            end
            ST_B_RD:  state_ff <= ST_B_MUL;
            ST_B_MUL: begin
               prod_ff  <= mul_p;
               state_ff <= ST_B_ACC1;
            end
            ST_B_ACC1: begin
               row_acc_ff[cnt_ff[IW-1:0]] <= acc_add(row_acc_ff[cnt_ff[IW-1:0]], prod_ff);
               prod_ff  <= mul_p;
               state_ff <= ST_B_ACC2;
            end
            ST_B_ACC2: begin
               grad_vld_ff[g_addr] <= 1'b1;
               cnt_ff <= cnt_ff + CW'(1);
               state_ff <= ((cnt_ff + CW'(1)) == n_in) ? ST_POST : ST_B_RD;
            end
            ST_POST: begin
               cnt_ff <= '0;
               if (rend_ff && n_emit != '0) begin
                  state_ff <= ST_EMIT;
               end else begin
                  if (rend_ff) begin
                     for (int k = 0; k < ACC_LEN; k++) row_acc_ff[k] <= '0;
                  end
                  state_ff <= ST_UCHK;
               end
            end
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= (op_ff == OP_BACKWARD);
                  rsp_row_ff   <= row_ff;
                  rsp_index_ff <= FIDX_W'(cnt_ff);
                  rsp_value_ff <= round_acc(row_acc_ff[cnt_ff[IW-1:0]]);
                  rsp_last_ff  <= emit_last;
                  cnt_ff       <= cnt_ff + CW'(1);
                  if (emit_last) begin
                     for (int k = 0; k < ACC_LEN; k++) row_acc_ff[k] <= '0;
                     state_ff <= ST_UCHK;
                  end
               end
            end
            ST_UCHK: begin
               ui_ff <= '0;
               uj_ff <= '0;
               if (op_ff == OP_BACKWARD && bend_ff) begin
                  if (n_in != '0 && n_out != '0) begin
                     state_ff <= ST_U_RD;
                  end else begin
                     grad_vld_ff <= '0;
                     state_ff    <= ST_IDLE;
                  end
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_U_RD:  state_ff <= ST_U_MLO;
            ST_U_MLO: begin
               prod_ff  <= mul_p;
               state_ff <= ST_U_MHI;
            end
            ST_U_MHI: begin
               usum_ff  <= USW'(prod_ff);
               prod_ff  <= mul_p;
               state_ff <= ST_U_SUM;
            end
            ST_U_SUM: begin
               step_ff  <= (u_rnd > U_MAX) ? VB'(U_MAX) :
                           (u_rnd < U_MIN) ? VB'(U_MIN) : VB'(u_rnd);
               state_ff <= ST_U_WR;
            end
            ST_U_WR: begin
               if ((uj_ff + CW'(1)) == n_out) begin
                  uj_ff <= '0;
                  ui_ff <= ui_ff + CW'(1);
               end else begin
                  uj_ff <= uj_ff + CW'(1);
               end
               if (upd_last) begin
                  grad_vld_ff <= '0;
                  state_ff    <= ST_IDLE;
               end else begin
                  state_ff <= ST_U_RD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_kind_ff;
   assign rsp_chan.result_row   = rsp_row_ff;
   assign rsp_chan.result_index = rsp_index_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.last         = rsp_last_ff;

`ifndef ASSERT_OFF
   a_row_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      (emit_go && emit_last) |=> (row_acc_ff[0] == '0))
      else $error("row accumulators not cleared after the last result");

   a_grad_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_U_WR && upd_last) |=> (grad_vld_ff == '0))
      else $error("gradient accumulators not cleared after the weight update");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_chan.opcode == OP_FORWARD || req_chan.opcode == OP_BACKWARD))
      |=> !req_chan.ready)
      else $error("request taken while an element is in progress");
`endif

endmodule

// File: tb/dense_layer_sgd_engine_core_tb.sv
// Self-checking testbench for dense_layer_sgd_engine_core: a directed table, then
// random forward/backward batches under several register settings and idling phases.
// Depends on dls_pkg, dls_req_if, dls_rsp_if and the engine core.
module dense_layer_sgd_engine_core_tb;
   import dls_pkg::*;

   typedef struct {
      opcode_type         op;
      logic [4:0]         row;
      logic [3:0]         ii;
      logic [3:0]         oi;
      logic signed [15:0] val;
      bit                 re;
      bit                 be;
   } elem_t;

   typedef struct {
      elem_t              e;
      bit                 typed;
      logic signed [15:0] tv;
   } step_t;

   typedef struct {
      logic               kind;
      logic [4:0]         row;
      logic [3:0]         idx;
      logic signed [15:0] value;
      logic               last;
   } result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_LEARN_RATE;
   logic [CSR_W-1:0] csr_wdata = '0;

   dls_req_if req_chan ();
   dls_rsp_if rsp_chan ();

   dense_layer_sgd_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   longint weights [16][16];
   longint xstore [32][16];
   bit     xwritten [32][16];
   longint row_acc [16];
   longint grad_acc [16][16];
   longint learn_rate;
   int     n_in;
   int     n_out;

   result_t pending_results [$];
   step_t   directed [$];
   int      errors = 0;
   int      requests = 0;
   int      results_seen = 0;
   int      settings_run = 0;
   int      idle_pct = 0;
   int      stall_pct = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #8000000;
      $display("Timeout at %0t", $time);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic longint sat(longint x, int bits);
      longint hi;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
   endfunction

   function automatic longint acc_add(longint a, longint p);
      if (p > (64'sd1 <<< 50)) p = 64'sd1 <<< 50;
      if (p < -(64'sd1 <<< 50)) p = -(64'sd1 <<< 50);
      return sat(a + p, ACC_BITS);
   endfunction

   function automatic longint round_q(longint x, int s);
      return sat((x + (64'sd1 <<< (s - 1))) >>> s, 16);
   endfunction

   function automatic int feature_count(int v);
      return (v > 16) ? 16 : v;
   endfunction

   task automatic predict_layer(elem_t e, bit typed, logic signed [15:0] tv);
      longint v;
      int n;
      int first;
      result_t r;
      v = longint'(e.val);
      n = 0;
      first = pending_results.size();
      case (e.op)
         OP_WEIGHT: begin
            if (e.ii < n_in && e.oi < n_out) weights[e.ii][e.oi] = v;
            return;
         end
         OP_NONE: return;
         OP_FORWARD: begin
            if (e.ii < n_in) begin
               xstore[e.row][e.ii] = v;
               xwritten[e.row][e.ii] = 1'b1;
               for (int j = 0; j < n_out; j++)
                  row_acc[j] = acc_add(row_acc[j], v * weights[e.ii][j]);
            end
            if (e.re) n = n_out;
         end
         default: begin
            if (e.oi < n_out) begin
               for (int i = 0; i < n_in; i++) begin
                  row_acc[i] = acc_add(row_acc[i], v * weights[i][e.oi]);
                  grad_acc[i][e.oi] = acc_add(grad_acc[i][e.oi], xstore[e.row][i] * v);
               end
            end
            if (e.re) n = n_in;
         end
      endcase
      if (e.re) begin
         for (int k = 0; k < n; k++) begin
            r.kind = (e.op == OP_BACKWARD);
            r.row = e.row;
            r.idx = k[3:0];
            r.value = 16'(round_q(row_acc[k], 12));
            r.last = (k + 1 == n);
            pending_results.push_back(r);
         end
         for (int k = 0; k < 16; k++) row_acc[k] = 0;
         if (typed && n > 0) pending_results[first].value = tv;
      end
      if (e.op == OP_BACKWARD && e.be) begin
         for (int i = 0; i < n_in; i++)
            for (int j = 0; j < n_out; j++)
               weights[i][j] = sat(weights[i][j] - round_q(grad_acc[i][j] * learn_rate, 28),
                                   16);
         for (int i = 0; i < 16; i++)
            for (int j = 0; j < 16; j++) grad_acc[i][j] = 0;
      end
   endtask

   task automatic send_request(elem_t e, bit typed = 0, logic signed [15:0] tv = '0);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= e.op;
      req_chan.batch_row <= e.row;
      req_chan.in_index <= e.ii;
      req_chan.out_index <= e.oi;
      req_chan.value <= e.val;
      req_chan.row_end <= e.re;
      req_chan.batch_end <= e.be;
      do @(posedge clock); while (!req_chan.ready);
      predict_layer(e, typed, tv);
      requests++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(data);
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LEARN_RATE: learn_rate = data & 16'hFFFF;
         CSR_IN_USED:    n_in = feature_count(data & 5'h1F);
         default:        n_out = feature_count(data & 5'h1F);
      endcase
   endtask

   function automatic logic signed [15:0] rand_value();
      if ($urandom_range(3) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 4095)) - 16'sd2048;
   endfunction

   function automatic elem_t make_elem(opcode_type op, int row, int ii, int oi,
                                       logic signed [15:0] val, bit re, bit be);
      elem_t e;
      e.op = op;
      e.row = 5'(row);
      e.ii = 4'(ii);
      e.oi = 4'(oi);
      e.val = val;
      e.re = re;
      e.be = be;
      return e;
   endfunction

   function automatic bit backward_ok(elem_t e);
      if (e.oi >= n_out) return 1'b1;
      for (int i = 0; i < n_in; i++)
         if (!xwritten[e.row][i]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic send_noise();
      elem_t e;
      e = make_elem(opcode_type'($urandom_range(3)), $urandom_range(31), $urandom_range(15),
                    $urandom_range(15), rand_value(), $urandom_range(1), $urandom_range(1));
      if (e.op == OP_BACKWARD && !backward_ok(e)) e.op = OP_FORWARD;
      send_request(e);
   endtask

   task automatic run_batch();
      int nrows;
      int rows [4];
      nrows = (n_in + n_out > 16) ? 1 : $urandom_range(1, 3);
      for (int r = 0; r < nrows; r++) rows[r] = $urandom_range(31);
      for (int r = 0; r < nrows; r++) begin
         if ($urandom_range(9) == 0) send_noise();
         if (n_in == 0)
            send_request(make_elem(OP_FORWARD, rows[r], $urandom_range(15), 0,
                                   rand_value(), 1, 0));
         else
            for (int i = 0; i < n_in; i++)
               send_request(make_elem(OP_FORWARD, rows[r], i, $urandom_range(15),
                                      rand_value(), i == n_in - 1, $urandom_range(1)));
      end
      for (int r = 0; r < nrows; r++) begin
         if ($urandom_range(9) == 0) send_noise();
         if (n_out == 0)
            send_request(make_elem(OP_BACKWARD, rows[r], 0, $urandom_range(15),
                                   rand_value(), 1, r == nrows - 1));
         else
            for (int o = 0; o < n_out; o++)
               send_request(make_elem(OP_BACKWARD, rows[r], $urandom_range(15), o,
                                      rand_value(), o == n_out - 1,
                                      (o == n_out - 1) && (r == nrows - 1)));
      end
   endtask

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      result_t r;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: actual row %0d index %0d value %0h",
                     $time, rsp_chan.result_row, rsp_chan.result_index,
                     rsp_chan.result_value);
            errors++;
         end else begin
            r = pending_results.pop_front();
            check_field("kind", r.kind, rsp_chan.kind);
            check_field("result_row", r.row, rsp_chan.result_row);
            check_field("result_index", r.idx, rsp_chan.result_index);
            check_field("result_value", 16'(r.value), 16'(rsp_chan.result_value));
            check_field("last", r.last, rsp_chan.last);
         end
      end
   end

   initial begin
      int target;
      int lr_set [7] = '{655, 65535, 0, 1234, 300, 20000, 655};
      int in_set [7] = '{16, 16, 1, 0, 31, 3, 16};
      int out_set [7] = '{16, 16, 1, 5, 31, 7, 16};
      int batches;

      req_chan.valid = 1'b0;
      req_chan.opcode = OP_NONE;
      req_chan.batch_row = '0;
      req_chan.in_index = '0;
      req_chan.out_index = '0;
      req_chan.value = '0;
      req_chan.row_end = 1'b0;
      req_chan.batch_end = 1'b0;
      rsp_chan.ready = 1'b0;
      learn_rate = LEARN_RATE_RESET;
      n_in = 16;
      n_out = 16;
      for (int i = 0; i < 16; i++) begin
         row_acc[i] = 0;
         for (int j = 0; j < 16; j++) begin
            weights[i][j] = 0;
            grad_acc[i][j] = 0;
         end
      end
      for (int r = 0; r < 32; r++)
         for (int i = 0; i < 16; i++) begin
            xstore[r][i] = 0;
            xwritten[r][i] = 1'b0;
         end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < 16; i++)
         for (int j = 0; j < 16; j++)
            send_request(make_elem(OP_WEIGHT, 0, i, j, rand_value(), 0, 0));
      drain_results();
      write_csr(CSR_IN_USED, 1);

      directed.push_back('{make_elem(OP_WEIGHT, 0, 0, 0, 16'sh7FFF, 0, 0), 0, 0});
      directed.push_back('{make_elem(OP_FORWARD, 0, 0, 0, 16'sh7FFF, 1, 0), 1, 16'sh7FFF});
      directed.push_back('{make_elem(OP_FORWARD, 1, 0, 0, -16'sh8000, 1, 0), 1, -16'sh8000});
      directed.push_back('{make_elem(OP_WEIGHT, 0, 0, 0, 16'sh1000, 1, 1), 0, 0});
      directed.push_back('{make_elem(OP_FORWARD, 2, 0, 9, 16'sh1000, 1, 0), 1, 16'sh1000});
      directed.push_back('{make_elem(OP_FORWARD, 3, 0, 15, 16'sh0001, 1, 0), 1, 16'sh0001});
      directed.push_back('{make_elem(OP_NONE, 31, 15, 15, -16'sh0001, 1, 1), 0, 0});
      directed.push_back('{make_elem(OP_FORWARD, 4, 1, 0, 16'sh2000, 0, 1), 0, 0});
      directed.push_back('{make_elem(OP_FORWARD, 4, 0, 0, 16'sh0800, 1, 0), 0, 0});
      directed.push_back('{make_elem(OP_BACKWARD, 0, 15, 0, 16'sh1000, 1, 0), 1, 16'sh1000});
      directed.push_back('{make_elem(OP_BACKWARD, 1, 0, 3, 16'sh7FFF, 1, 1), 0, 0});
      directed.push_back('{make_elem(OP_BACKWARD, 2, 0, 15, -16'sh8000, 1, 0), 0, 0});
      directed.push_back('{make_elem(OP_FORWARD, 31, 0, 0, -16'sh8000, 1, 0), 0, 0});
      directed.push_back('{make_elem(OP_BACKWARD, 31, 0, 0, 16'sh0000, 1, 1), 1, 16'sh0000});
      directed.push_back('{make_elem(OP_FORWARD, 6, 15, 0, 16'sh7FFF, 1, 0), 1, 16'sh0000});
      foreach (directed[k]) send_request(directed[k].e, directed[k].typed, directed[k].tv);

      batches = 0;
      for (int s = 0; s < 7; s++) begin
         drain_results();
         write_csr(CSR_LEARN_RATE, (s == 5) ? $urandom_range(65535) : lr_set[s]);
         write_csr(CSR_IN_USED, in_set[s]);
         write_csr(CSR_OUT_USED, out_set[s]);
         settings_run++;
         target = requests + 8;
         while (requests < target) begin
            case (batches % 4)
               0: begin idle_pct = 0; stall_pct = 0; end
               1: begin idle_pct = 80; stall_pct = 0; end
               2: begin idle_pct = 0; stall_pct = 80; end
               default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            run_batch();
            batches++;
         end
      end

      drain_results();
      $display("Sent %0d requests in %0d batches over %0d register settings;",
               requests, batches, settings_run);
      $display("checked %0d results with idle and stall phases.", results_seen);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

// File: sim.f
src/dls_pkg.sv
src/dls_req_if.sv
src/dls_rsp_if.sv
src/dense_layer_sgd_engine_core.sv
tb/dense_layer_sgd_engine_core_tb.sv
